// File: src/assert_macros.svh
// Assertion helpers shared by the frame parser modules.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GBFP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gbfp assertion failed");

// Condition that must never be true outside reset.
`define GBFP_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gbfp forbidden condition seen");

`endif

// File: src/gbfp_pkg.sv
// Shared types and constants for the binary frame parser.
// No dependencies; imported by every module of the block but the output port checker.
`timescale 1ns / 1ps

package gbfp_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 56;
    localparam int TUSER_W    = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CLASS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_ID    = 3'd4;

    // Reset values of the registers
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST   = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST  = 8'h62;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST = 16'd100;
    localparam logic [BYTE_W-1:0] WANTED_CLASS_RST = 8'h01;
    localparam logic [BYTE_W-1:0] WANTED_ID_RST    = 8'h07;

    // Frame status codes
    localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [LEN_W-1:0]  length_limit;
        logic [BYTE_W-1:0] wanted_class;
        logic [BYTE_W-1:0] wanted_id;
    } gbfp_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic [LEN_W-1:0]    payload_index;
        logic                payload_valid;
        logic                frame_end;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   frame_class;
        logic [BYTE_W-1:0]   frame_id;
        logic [LEN_W-1:0]    frame_length;
        logic                frame_wanted;
    } gbfp_result_t;

endpackage

// File: src/gbfp_cfg_regs.sv
// Configuration register file of the frame parser.
// Depends on gbfp_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module gbfp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gbfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbfp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output gbfp_pkg::gbfp_cfg_t               cfg
);
    import gbfp_pkg::*;

    gbfp_cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first   <= SYNC_FIRST_RST;
            cfg_reg.sync_second  <= SYNC_SECOND_RST;
            cfg_reg.length_limit <= LENGTH_LIMIT_RST;
            cfg_reg.wanted_class <= WANTED_CLASS_RST;
            cfg_reg.wanted_id    <= WANTED_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:   cfg_reg.sync_first   <= cfg_wdata[BYTE_W-1:0];
                CFG_SYNC_SECOND:  cfg_reg.sync_second  <= cfg_wdata[BYTE_W-1:0];
                CFG_LENGTH_LIMIT: cfg_reg.length_limit <= cfg_wdata[LEN_W-1:0];
                CFG_WANTED_CLASS: cfg_reg.wanted_class <= cfg_wdata[BYTE_W-1:0];
                CFG_WANTED_ID:    cfg_reg.wanted_id    <= cfg_wdata[BYTE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/gbfp_frame_fsm.sv
// Frame state machine: sync hunt, header, payload and checksum tracking.
// Depends on gbfp_pkg and assert_macros.svh; result goes to the output buffer.
`timescale 1ns / 1ps

module gbfp_frame_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gbfp_pkg::gbfp_cfg_t            cfg,
    input  logic                           in_fire,
    input  logic [gbfp_pkg::BYTE_W-1:0]    rx_byte,
    output gbfp_pkg::gbfp_result_t         result
);
    import gbfp_pkg::*;

    localparam logic [2:0] PH_SYNC1   = 3'd0;
    localparam logic [2:0] PH_SYNC2   = 3'd1;
    localparam logic [2:0] PH_HEAD    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [2:0]        phase_reg,   phase_next;
    logic [LEN_W-1:0]  count_reg,   count_next;
    logic [BYTE_W-1:0] sum_a_reg,   sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg,   sum_b_next;
    logic [BYTE_W-1:0] class_reg,   class_next;
    logic [BYTE_W-1:0] id_reg,      id_next;
    logic [LEN_W-1:0]  length_reg,  length_next;
    logic [BYTE_W-1:0] check_a_reg, check_a_next;

    logic [BYTE_W-1:0] add_a;
    logic [BYTE_W-1:0] add_b;
    logic [LEN_W-1:0]  full_length;
    logic [LEN_W:0]    count_inc;
    logic              sum_ok;

    // Fletcher running sums for the current byte
    assign add_a       = sum_a_reg + rx_byte;
    assign add_b       = sum_b_reg + add_a;
    assign full_length = {rx_byte, length_reg[BYTE_W-1:0]};
    assign count_inc   = {1'b0, count_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign sum_ok      = (check_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);

    // Per-byte step
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        class_next   = class_reg;
        id_next      = id_reg;
        length_next  = length_reg;
        check_a_next = check_a_reg;

        result.payload_byte  = '0;
        result.payload_index = '0;
        result.payload_valid = 1'b0;
        result.frame_end     = 1'b0;
        result.frame_status  = STATUS_GOOD;
        result.frame_wanted  = 1'b0;

        case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == cfg.sync_first)
                    phase_next = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                // a mismatch drops the byte and restarts the hunt
                if (rx_byte == cfg.sync_second)
                begin
                    phase_next = PH_HEAD;
                    count_next = '0;
                    sum_a_next = '0;
                    sum_b_next = '0;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_HEAD:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                case (count_reg[1:0])
                    2'd0:
                    begin
                        class_next = rx_byte;
                        count_next = count_inc[LEN_W-1:0];
                    end
                    2'd1:
                    begin
                        id_next    = rx_byte;
                        count_next = count_inc[LEN_W-1:0];
                    end
                    2'd2:
                    begin
                        length_next = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
                        count_next  = count_inc[LEN_W-1:0];
                    end
                    default:
                    begin
                        length_next = full_length;
                        count_next  = '0;
                        if (full_length >= cfg.length_limit)
                        begin
                            result.frame_end    = 1'b1;
                            result.frame_status = STATUS_TOO_LONG;
                            phase_next          = PH_SYNC1;
                        end
                        else if (full_length == '0)
                            phase_next = PH_CHECK;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                endcase
            end
            PH_PAYLOAD:
            begin
                sum_a_next           = add_a;
                sum_b_next           = add_b;
                result.payload_byte  = rx_byte;
                result.payload_index = count_reg;
                result.payload_valid = 1'b1;
                if (count_inc >= {1'b0, length_reg})
                begin
                    count_next = '0;
                    phase_next = PH_CHECK;
                end
                else
                begin
                    count_next = count_inc[LEN_W-1:0];
                end
            end
            PH_CHECK:
            begin
                if (count_reg == '0)
                begin
                    check_a_next = rx_byte;
                    count_next   = count_inc[LEN_W-1:0];
                end
                else
                begin
                    result.frame_end    = 1'b1;
                    result.frame_status = sum_ok ? STATUS_GOOD : STATUS_BAD_SUM;
                    result.frame_wanted = sum_ok && (class_reg == cfg.wanted_class)
                                          && (id_reg == cfg.wanted_id);
                    count_next          = '0;
                    phase_next          = PH_SYNC1;
                end
            end
            default:
            begin
                phase_next = PH_SYNC1;
                count_next = '0;
            end
        endcase

        result.frame_class  = class_next;
        result.frame_id     = id_next;
        result.frame_length = length_next;
    end

    // State update on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            count_reg   <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            class_reg   <= '0;
            id_reg      <= '0;
            length_reg  <= '0;
            check_a_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            class_reg   <= class_next;
            id_reg      <= id_next;
            length_reg  <= length_next;
            check_a_reg <= check_a_next;
        end
    end

`include "assert_macros.svh"

    `GBFP_ASSERT(a_head_count, (phase_reg == PH_HEAD) |-> (count_reg <= 16'd3))
    `GBFP_ASSERT(a_payload_idx, (phase_reg == PH_PAYLOAD) |-> (count_reg < length_reg))
    `GBFP_NEVER(a_end_and_payload, result.payload_valid && result.frame_end)
    `GBFP_ASSERT(a_end_rehunt, (in_fire && result.frame_end) |=> (phase_reg == PH_SYNC1))

endmodule

// File: src/gbfp_out_buf.sv
// Result register with one skid entry between the parser and the output stream.
// Depends on gbfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module gbfp_out_buf (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  gbfp_pkg::gbfp_result_t    result,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output gbfp_pkg::gbfp_result_t    out_result
);
    import gbfp_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    gbfp_result_t out_reg;
    gbfp_result_t skid_reg;
    logic         out_open;

    assign out_open = !out_valid_reg || out_ready;

    // Control: output register refills from skid first, then from the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_open)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_fire;
                end
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (out_open)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_fire)
                out_reg <= result;
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    assign in_ready   = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

`include "assert_macros.svh"

    `GBFP_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg)
    `GBFP_ASSERT(a_stall_to_skid, (in_fire && out_valid_reg && !out_ready) |=> skid_valid_reg)
    `GBFP_ASSERT(a_skid_drains, (skid_valid_reg && out_ready) |=> !skid_valid_reg)

endmodule

// File: src/gbfp_out_buf_unused_guard.sv
// Stream port checker for the frame parser output channel.
// Depends on assert_macros.svh; sees only the output ports.
`timescale 1ns / 1ps

module gbfp_out_buf_unused_guard (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tlast,
    input logic [3:0]  m_tuser
);
    logic dummy_reg;

    // Records whether the last transferred result ended a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dummy_reg <= 1'b0;
        else if (m_tvalid && m_tready)
            dummy_reg <= m_tlast;
    end

`include "assert_macros.svh"

    `GBFP_ASSERT(a_hold_valid, (m_tvalid && !m_tready) |=> m_tvalid)
    `GBFP_ASSERT(a_status_on_end, (m_tvalid && (m_tuser[2:1] != 2'd0)) |-> m_tlast)
    `GBFP_NEVER(a_payload_on_end, m_tvalid && m_tuser[0] && m_tlast)
    `GBFP_ASSERT(a_wanted_good, (m_tvalid && m_tuser[3]) |-> (m_tlast && !m_tuser[1] && !dummy_reg))

endmodule

// File: src/gnss_binary_frame_parser_core.sv
// Binary frame parser for a serial GNSS byte stream: one input byte per request,
// one result per byte. This is the top level; it uses gbfp_pkg and all gbfp_* modules.
//
// Channels: bytes arrive on s_tvalid/s_tready/s_tdata; each accepted byte yields
// exactly one result on m_tvalid/m_tready/m_tdata/m_tuser/m_tlast.
//   m_tdata [7:0] payload_byte, [23:8] payload_index, [31:24] frame_class,
//           [39:32] frame_id, [55:40] frame_length
//   m_tuser [0] payload_valid, [2:1] frame_status, [3] frame_wanted
//   m_tlast frame_end (last checksum byte, or length rejection)
// Throughput: one byte per cycle while the skid entry is empty; the whole per-byte step
// (sync match, header capture, Fletcher sums, compare) is one combinational pass into the
// result register, or into the skid entry when the result register is held.
// Stall: one skid entry holds a result while m_tready is low; s_tready drops only
// when both the result register and the skid entry are full.
// Reset: parser returns to the sync hunt, held class/id/length clear, registers
// take their default values, output channel empties.
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle:
//   0 sync_first, 1 sync_second, 2 length_limit, 3 wanted_class, 4 wanted_id.
`timescale 1ns / 1ps

module gnss_binary_frame_parser_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gbfp_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gbfp_pkg::TDATA_W-1:0]        m_tdata,   // payload_byte, payload_index,
                                                           // frame_class, frame_id,
                                                           // frame_length
    output logic [gbfp_pkg::TUSER_W-1:0]        m_tuser,   // payload_valid, frame_status,
                                                           // frame_wanted
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [gbfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbfp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import gbfp_pkg::*;

    gbfp_cfg_t    cfg;
    gbfp_result_t step_result;
    gbfp_result_t out_result;
    logic         in_ready;
    logic         in_fire;

    assign s_tready = in_ready;
    assign in_fire  = s_tvalid && in_ready;

    gbfp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gbfp_frame_fsm u_frame_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_fire (in_fire),
        .rx_byte (s_tdata),
        .result  (step_result)
    );

    gbfp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .result     (step_result),
        .in_ready   (in_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    gbfp_out_buf_unused_guard u_port_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Output packing, lowest field first
    assign m_tdata = {out_result.frame_length, out_result.frame_id, out_result.frame_class,
                      out_result.payload_index, out_result.payload_byte};
    assign m_tuser = {out_result.frame_wanted, out_result.frame_status,
                      out_result.payload_valid};
    assign m_tlast = out_result.frame_end;

endmodule

// File: sim/gnss_binary_frame_parser_core_tb.sv
// Self-checking testbench for gnss_binary_frame_parser_core: drives byte streams of
// directed and random frames and checks every result against a cycle-free parser model.
// Depends on gbfp_pkg and the parser RTL; nothing else is read.
`timescale 1ns / 1ps

module gnss_binary_frame_parser_core_tb;
    import gbfp_pkg::*;

    localparam int STUCK_LIMIT = 1000;
    localparam int LONG_HOLD   = 60;
    localparam int IDLE_PCT    = 26;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        HEADER,
        PAYLOAD,
        CHECKSUM
    } parse_phase_t;

    // Untimed parser: one expected result per accepted byte
    class frame_parse_tracker_t;
        logic [BYTE_W-1:0] sync_first, sync_second, wanted_class, wanted_id;
        logic [LEN_W-1:0]  length_limit;

        parse_phase_t      phase;
        logic [16:0]       byte_count;
        logic [BYTE_W-1:0] sum_a, sum_b, held_class, held_id, first_check;
        logic [LEN_W-1:0]  held_length;

        gbfp_result_t      pending_results[$];
        int                mismatches;

        function new();
            sync_first   = SYNC_FIRST_RST;
            sync_second  = SYNC_SECOND_RST;
            length_limit = LENGTH_LIMIT_RST;
            wanted_class = WANTED_CLASS_RST;
            wanted_id    = WANTED_ID_RST;
            phase        = HUNT_FIRST;
            byte_count   = '0;
            sum_a        = '0;
            sum_b        = '0;
            held_class   = '0;
            held_id      = '0;
            held_length  = '0;
            first_check  = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SYNC_FIRST:   sync_first   = val[7:0];
                CFG_SYNC_SECOND:  sync_second  = val[7:0];
                CFG_LENGTH_LIMIT: length_limit = val;
                CFG_WANTED_CLASS: wanted_class = val[7:0];
                CFG_WANTED_ID:    wanted_id    = val[7:0];
                default: ;
            endcase
        endfunction

        function void add_to_sums(logic [BYTE_W-1:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            gbfp_result_t r;
            logic         good;
            r = '0;
            case (phase)
                HUNT_FIRST:
                begin
                    if (b == sync_first)
                        phase = HUNT_SECOND;
                end
                HUNT_SECOND:
                begin
                    // a mismatching byte is dropped, not re-tested as a first sync
                    if (b == sync_second)
                    begin
                        phase      = HEADER;
                        byte_count = '0;
                        sum_a      = '0;
                        sum_b      = '0;
                    end
                    else
                        phase = HUNT_FIRST;
                end
                HEADER:
                begin
                    add_to_sums(b);
                    if (byte_count == 0)
                    begin
                        held_class = b;
                        byte_count = 17'd1;
                    end
                    else if (byte_count == 1)
                    begin
                        held_id    = b;
                        byte_count = 17'd2;
                    end
                    else if (byte_count == 2)
                    begin
                        held_length = {8'h00, b};
                        byte_count  = 17'd3;
                    end
                    else
                    begin
                        held_length[15:8] = b;
                        byte_count        = '0;
                        if (held_length >= length_limit)
                        begin
                            r.frame_end    = 1'b1;
                            r.frame_status = STATUS_TOO_LONG;
                            phase          = HUNT_FIRST;
                        end
                        else if (held_length == 0)
                            phase = CHECKSUM;
                        else
                            phase = PAYLOAD;
                    end
                end
                PAYLOAD:
                begin
                    add_to_sums(b);
                    r.payload_byte  = b;
                    r.payload_index = byte_count[15:0];
                    r.payload_valid = 1'b1;
                    byte_count      = byte_count + 17'd1;
                    if (byte_count >= {1'b0, held_length})
                    begin
                        byte_count = '0;
                        phase      = CHECKSUM;
                    end
                end
                default:
                begin
                    if (byte_count == 0)
                    begin
                        first_check = b;
                        byte_count  = 17'd1;
                    end
                    else
                    begin
                        good           = (first_check == sum_a) && (b == sum_b);
                        r.frame_end    = 1'b1;
                        r.frame_status = good ? STATUS_GOOD : STATUS_BAD_SUM;
                        r.frame_wanted = good && held_class == wanted_class
                                         && held_id == wanted_id;
                        byte_count     = '0;
                        phase          = HUNT_FIRST;
                    end
                end
            endcase
            r.frame_class  = held_class;
            r.frame_id     = held_id;
            r.frame_length = held_length;
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (exp_val !== act_val)
            begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void match_result(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser,
                                   logic tlast);
            gbfp_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result with no byte outstanding: tdata %0h", tdata);
                mismatches++;
                return;
            end
            e = pending_results.pop_front();
            check_field("payload_byte",  16'(e.payload_byte),  16'(tdata[7:0]));
            check_field("payload_index", e.payload_index,      tdata[23:8]);
            check_field("frame_class",   16'(e.frame_class),   16'(tdata[31:24]));
            check_field("frame_id",      16'(e.frame_id),      16'(tdata[39:32]));
            check_field("frame_length",  e.frame_length,       tdata[55:40]);
            check_field("payload_valid", 16'(e.payload_valid), 16'(tuser[0]));
            check_field("frame_status",  16'(e.frame_status),  16'(tuser[2:1]));
            check_field("frame_wanted",  16'(e.frame_wanted),  16'(tuser[3]));
            check_field("frame_end",     16'(e.frame_end),     16'(tlast));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;    // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;    // payload_byte, payload_index, frame_class,
                                       // frame_id, frame_length
    logic [TUSER_W-1:0]    m_tuser;    // payload_valid, frame_status, frame_wanted
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    frame_parse_tracker_t  tracker = new();
    logic [BYTE_W-1:0]     tx_q[$];
    bit                    no_idle;
    bit                    hold_request;
    int                    stuck_cycles;

    gnss_binary_frame_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Watchdog: too long without any request moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Result side: random stalls, one long hold when asked
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
                m_tready    <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tracker.match_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // Byte side: offers the queue in order, holds a request until taken
    task automatic send_bytes();
        bit offered;
        offered = 1'b0;
        while (tx_q.size() > 0)
        begin
            @(negedge clk);
            if (!offered)
            begin
                if (!no_idle && $urandom_range(99) < IDLE_PCT)
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_q[0];
                    offered   = 1'b1;
                end
            end
            @(posedge clk);
            if (offered && s_tready)
            begin
                tracker.take_byte(tx_q.pop_front());
                offered = 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tracker.pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [15:0] lim, input logic [7:0] cls,
                             input logic [7:0] id);
        write_reg(CFG_SYNC_FIRST, {8'h00, s1});
        write_reg(CFG_SYNC_SECOND, {8'h00, s2});
        write_reg(CFG_LENGTH_LIMIT, lim);
        write_reg(CFG_WANTED_CLASS, {8'h00, cls});
        write_reg(CFG_WANTED_ID, {8'h00, id});
    endtask

    // Appends one frame with the current sync bytes; a rejected length stops at the header
    task automatic build_frame(input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len, input bit corrupt);
        logic [7:0] body[$];
        logic [7:0] ck_a, ck_b;
        body = {cls, id, len[7:0], len[15:8]};
        if (len < tracker.length_limit)
            repeat (len) body.push_back(8'($urandom));
        ck_a = '0;
        ck_b = '0;
        foreach (body[i])
        begin
            ck_a = ck_a + body[i];
            ck_b = ck_b + ck_a;
        end
        if (corrupt)
        begin
            if ($urandom_range(1) == 0)
                ck_a = ck_a ^ (8'h01 << $urandom_range(7));
            else
                ck_b = ck_b ^ (8'h01 << $urandom_range(7));
        end
        tx_q.push_back(tracker.sync_first);
        tx_q.push_back(tracker.sync_second);
        foreach (body[i])
            tx_q.push_back(body[i]);
        if (len < tracker.length_limit)
        begin
            tx_q.push_back(ck_a);
            tx_q.push_back(ck_b);
        end
    endtask

    // Mostly short payloads, now and then the longest one the limit lets through
    function automatic logic [15:0] pick_len();
        int lim;
        lim = int'(tracker.length_limit);
        if (lim == 0)
            return 16'($urandom_range(8));
        if (lim <= 128 && $urandom_range(99) < 8)
            return 16'(lim - 1);
        return 16'($urandom_range((lim - 1 < 8) ? lim - 1 : 8));
    endfunction

    task automatic random_traffic(input int n_bytes);
        int         kind;
        logic [7:0] cls, id;
        while (tx_q.size() < n_bytes)
        begin
            kind = $urandom_range(99);
            if ($urandom_range(3) == 0)
            begin
                cls = tracker.wanted_class;
                id  = tracker.wanted_id;
            end
            else
            begin
                cls = 8'($urandom);
                id  = 8'($urandom);
            end
            if (kind < 72)
                build_frame(cls, id, pick_len(), kind >= 60);
            else if (kind < 82)
                build_frame(cls, id, 16'($urandom_range(65535, tracker.length_limit)), 1'b0);
            else
            begin
                // line noise, with stray first sync bytes
                repeat ($urandom_range(6, 1))
                    tx_q.push_back(($urandom_range(2) == 0) ? tracker.sync_first
                                                           : 8'($urandom));
            end
        end
        send_bytes();
    endtask

    initial
    begin
        logic [7:0] frame_rest[$];
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        stuck_cycles = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: wanted empty frame, second sync miss on a first sync value,
        // rejection at the limit and at full length, bad checksum
        build_frame(WANTED_CLASS_RST, WANTED_ID_RST, 16'd0, 1'b0);
        tx_q.push_back(SYNC_FIRST_RST);
        tx_q.push_back(SYNC_FIRST_RST);
        tx_q.push_back(SYNC_SECOND_RST);
        build_frame(8'h10, 8'h20, LENGTH_LIMIT_RST, 1'b0);
        build_frame(8'hFF, 8'h00, 16'hFFFF, 1'b0);
        build_frame(8'h00, 8'hFF, 16'd2, 1'b1);
        send_bytes();

        // Defaults, with the result side held off for a while
        hold_request = 1'b1;
        random_traffic(70);
        wait_idle();

        // Low extremes of the sync bytes, smallest usable limit
        write_all(8'h00, 8'hFF, 16'd1, 8'hFF, 8'h00);
        random_traffic(70);
        wait_idle();

        // High extremes, no idling on either side
        write_all(8'hFF, 8'h00, 16'hFFFF, 8'h00, 8'hFF);
        no_idle = 1'b1;
        random_traffic(80);
        no_idle = 1'b0;
        wait_idle();

        // Zero limit rejects everything; writes past the register list are dropped
        write_reg(CFG_LENGTH_LIMIT, 16'd0);
        for (int i = CFG_WANTED_ID + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        random_traffic(40);
        wait_idle();

        // Random settings, limit small enough to reach it now and then
        write_all(8'($urandom), 8'($urandom), 16'($urandom_range(120, 1)),
                  8'($urandom), 8'($urandom));
        hold_request = 1'b1;
        random_traffic(120);
        wait_idle();

        // Back to defaults: a payload of length 99, then a wanted pair changed mid-frame
        write_all(SYNC_FIRST_RST, SYNC_SECOND_RST, LENGTH_LIMIT_RST,
                  WANTED_CLASS_RST, WANTED_ID_RST);
        build_frame(8'h05, 8'h01, 16'd99, 1'b0);
        send_bytes();
        build_frame(8'h22, 8'h33, 16'd3, 1'b0);
        frame_rest = tx_q[4:$];
        tx_q       = tx_q[0:3];
        send_bytes();
        wait_idle();
        write_reg(CFG_WANTED_CLASS, 16'h0022);
        write_reg(CFG_WANTED_ID, 16'h0033);
        tx_q = frame_rest;
        send_bytes();
        random_traffic(40);

        wait_idle();
        repeat (5) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/gbfp_pkg.sv
src/gbfp_cfg_regs.sv
src/gbfp_frame_fsm.sv
src/gbfp_out_buf.sv
src/gbfp_out_buf_unused_guard.sv
src/gnss_binary_frame_parser_core.sv
sim/gnss_binary_frame_parser_core_tb.sv
